// File: design/lodtri_pkg.sv
// Shared types, constants and triangle shape tables for the LOD grid index generator.
package lodtri_pkg;

  localparam int SEG_W       = 9;
  localparam int STRIDE_W    = SEG_W + 1;
  localparam int IDX_W       = 17;
  localparam int VAR_W       = 4;
  localparam int REGION_W    = 3;
  localparam int CNT_W       = 2;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 56;
  localparam logic [SEG_W-1:0] SEG_MIN = SEG_W'(4);

  typedef enum logic [REGION_W-1:0] {
    REGION_INNER  = 3'd0,
    REGION_TOP    = 3'd1,
    REGION_RIGHT  = 3'd2,
    REGION_BOTTOM = 3'd3,
    REGION_LEFT   = 3'd4
  } region_t;

  typedef enum logic [0:0] {
    CFG_COLS = 1'b0,
    CFG_ROWS = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    SH_INNER_A,
    SH_INNER_B,
    SH_EVEN,
    SH_HI_A,
    SH_HI_B,
    SH_LO,
    SH_TAIL
  } shape_t;

  typedef enum logic [1:0] {
    OFS_MINUS,
    OFS_ZERO,
    OFS_PLUS
  } ofs_t;

  // row/col offsets of the three corners of one triangle
  typedef struct packed {
    ofs_t ar;
    ofs_t ac;
    ofs_t br;
    ofs_t bc;
    ofs_t cr;
    ofs_t cc;
  } tri_ofs_t;

  // one decoded cell, handed from the setup stage to the emitter
  typedef struct packed {
    region_t            region;
    shape_t             shape0;
    shape_t             shape1;
    shape_t             shape2;
    logic [CNT_W-1:0]   cnt;
    logic [IDX_W-1:0]   row_m;
    logic [IDX_W-1:0]   row_z;
    logic [IDX_W-1:0]   row_p;
    logic [SEG_W-1:0]   col_m;
    logic [SEG_W-1:0]   col_z;
    logic [SEG_W-1:0]   col_p;
  } cell_t;

  function automatic tri_ofs_t shape_ofs(region_t region, shape_t shape);
    tri_ofs_t t;
    t = '{OFS_ZERO, OFS_ZERO, OFS_ZERO, OFS_ZERO, OFS_ZERO, OFS_ZERO};
    unique case (region)
      REGION_INNER: begin
        unique case (shape)
          SH_INNER_A: t = '{OFS_ZERO, OFS_ZERO, OFS_PLUS, OFS_ZERO, OFS_ZERO, OFS_PLUS};
          SH_INNER_B: t = '{OFS_ZERO, OFS_PLUS, OFS_PLUS, OFS_ZERO, OFS_PLUS, OFS_PLUS};
          default:    t = '{OFS_ZERO, OFS_ZERO, OFS_ZERO, OFS_ZERO, OFS_ZERO, OFS_ZERO};
        endcase
      end
      REGION_TOP: begin
        unique case (shape)
          SH_EVEN: t = '{OFS_ZERO, OFS_ZERO, OFS_PLUS, OFS_ZERO, OFS_ZERO, OFS_PLUS};
          SH_HI_A: t = '{OFS_ZERO, OFS_ZERO, OFS_PLUS, OFS_MINUS, OFS_PLUS, OFS_ZERO};
          SH_HI_B: t = '{OFS_ZERO, OFS_ZERO, OFS_PLUS, OFS_ZERO, OFS_PLUS, OFS_PLUS};
          SH_LO:   t = '{OFS_ZERO, OFS_ZERO, OFS_PLUS, OFS_MINUS, OFS_PLUS, OFS_PLUS};
          SH_TAIL: t = '{OFS_ZERO, OFS_ZERO, OFS_PLUS, OFS_PLUS, OFS_ZERO, OFS_PLUS};
          default: t = '{OFS_ZERO, OFS_ZERO, OFS_ZERO, OFS_ZERO, OFS_ZERO, OFS_ZERO};
        endcase
      end
      REGION_RIGHT: begin
        unique case (shape)
          SH_EVEN: t = '{OFS_ZERO, OFS_ZERO, OFS_PLUS, OFS_ZERO, OFS_ZERO, OFS_PLUS};
          SH_HI_A: t = '{OFS_ZERO, OFS_ZERO, OFS_ZERO, OFS_PLUS, OFS_MINUS, OFS_PLUS};
          SH_HI_B: t = '{OFS_ZERO, OFS_ZERO, OFS_PLUS, OFS_PLUS, OFS_ZERO, OFS_PLUS};
          SH_LO:   t = '{OFS_ZERO, OFS_ZERO, OFS_PLUS, OFS_PLUS, OFS_MINUS, OFS_PLUS};
          SH_TAIL: t = '{OFS_ZERO, OFS_ZERO, OFS_PLUS, OFS_ZERO, OFS_PLUS, OFS_PLUS};
          default: t = '{OFS_ZERO, OFS_ZERO, OFS_ZERO, OFS_ZERO, OFS_ZERO, OFS_ZERO};
        endcase
      end
      REGION_BOTTOM: begin
        unique case (shape)
          SH_EVEN: t = '{OFS_ZERO, OFS_ZERO, OFS_PLUS, OFS_ZERO, OFS_PLUS, OFS_PLUS};
          SH_HI_A: t = '{OFS_ZERO, OFS_MINUS, OFS_PLUS, OFS_ZERO, OFS_ZERO, OFS_ZERO};
          SH_HI_B: t = '{OFS_ZERO, OFS_ZERO, OFS_PLUS, OFS_ZERO, OFS_ZERO, OFS_PLUS};
          SH_LO:   t = '{OFS_ZERO, OFS_MINUS, OFS_PLUS, OFS_ZERO, OFS_ZERO, OFS_PLUS};
          SH_TAIL: t = '{OFS_ZERO, OFS_PLUS, OFS_PLUS, OFS_ZERO, OFS_PLUS, OFS_PLUS};
          default: t = '{OFS_ZERO, OFS_ZERO, OFS_ZERO, OFS_ZERO, OFS_ZERO, OFS_ZERO};
        endcase
      end
      REGION_LEFT: begin
        unique case (shape)
          SH_EVEN: t = '{OFS_ZERO, OFS_ZERO, OFS_PLUS, OFS_PLUS, OFS_ZERO, OFS_PLUS};
          SH_HI_A: t = '{OFS_MINUS, OFS_ZERO, OFS_ZERO, OFS_ZERO, OFS_ZERO, OFS_PLUS};
          SH_HI_B: t = '{OFS_ZERO, OFS_ZERO, OFS_PLUS, OFS_ZERO, OFS_ZERO, OFS_PLUS};
          SH_LO:   t = '{OFS_MINUS, OFS_ZERO, OFS_PLUS, OFS_ZERO, OFS_ZERO, OFS_PLUS};
          SH_TAIL: t = '{OFS_ZERO, OFS_PLUS, OFS_PLUS, OFS_ZERO, OFS_PLUS, OFS_PLUS};
          default: t = '{OFS_ZERO, OFS_ZERO, OFS_ZERO, OFS_ZERO, OFS_ZERO, OFS_ZERO};
        endcase
      end
      default: t = '{OFS_ZERO, OFS_ZERO, OFS_ZERO, OFS_ZERO, OFS_ZERO, OFS_ZERO};
    endcase
    return t;
  endfunction

endpackage

// File: design/lodtri_emit.sv
// Triangle emitter: holds one decoded cell and sends its triangles through the output register.
module lodtri_emit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cell_valid,
  input  lodtri_pkg::cell_t                   cell_in,
  output logic                                cell_ready,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [lodtri_pkg::OUT_TDATA_W-1:0]  out_tdata,  // vertex_a, vertex_b, vertex_c, zero fill
  output logic                                out_tlast   // last
);

  logic                               s2_valid_r;
  lodtri_pkg::cell_t                  cell_r;
  logic [lodtri_pkg::CNT_W-1:0]       idx_r;
  logic                               out_valid_r;
  logic [lodtri_pkg::OUT_TDATA_W-1:0] out_tdata_r;
  logic                               out_tlast_r;

  logic                               out_free;
  logic                               fire;
  logic                               last_tri;
  lodtri_pkg::shape_t                 shape;
  lodtri_pkg::tri_ofs_t               ofs;
  logic [lodtri_pkg::IDX_W-1:0]       va;
  logic [lodtri_pkg::IDX_W-1:0]       vb;
  logic [lodtri_pkg::IDX_W-1:0]       vc;

  function automatic logic [lodtri_pkg::IDX_W-1:0] vertex(lodtri_pkg::cell_t c,
                                                          lodtri_pkg::ofs_t  dr,
                                                          lodtri_pkg::ofs_t  dc);
    logic [lodtri_pkg::IDX_W-1:0] rb;
    logic [lodtri_pkg::SEG_W-1:0] cb;
    unique case (dr)
      lodtri_pkg::OFS_MINUS: rb = c.row_m;
      lodtri_pkg::OFS_PLUS:  rb = c.row_p;
      default:               rb = c.row_z;
    endcase
    unique case (dc)
      lodtri_pkg::OFS_MINUS: cb = c.col_m;
      lodtri_pkg::OFS_PLUS:  cb = c.col_p;
      default:               cb = c.col_z;
    endcase
    return rb + lodtri_pkg::IDX_W'(cb);
  endfunction

  assign out_free   = !out_valid_r || out_tready;
  assign fire       = s2_valid_r && out_free;
  assign last_tri   = (idx_r == cell_r.cnt - lodtri_pkg::CNT_W'(1));
  assign cell_ready = !s2_valid_r || (fire && last_tri);

  always_comb begin
    unique case (idx_r)
      2'd0:    shape = cell_r.shape0;
      2'd1:    shape = cell_r.shape1;
      default: shape = cell_r.shape2;
    endcase
    ofs = lodtri_pkg::shape_ofs(cell_r.region, shape);
    va  = vertex(cell_r, ofs.ar, ofs.ac);
    vb  = vertex(cell_r, ofs.br, ofs.bc);
    vc  = vertex(cell_r, ofs.cr, ofs.cc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      idx_r      <= '0;
    end else if (cell_ready && cell_valid) begin
      s2_valid_r <= 1'b1;
      idx_r      <= '0;
    end else if (fire && last_tri) begin
      s2_valid_r <= 1'b0;
      idx_r      <= '0;
    end else if (fire) begin
      idx_r      <= idx_r + lodtri_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cell_ready && cell_valid) begin
      cell_r <= cell_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_tdata_r <= {5'b0, vc, vb, va};
      out_tlast_r <= last_tri;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

`ifndef NO_ASSERTIONS
  a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> (cell_r.cnt != '0))
    else $error("held cell has no triangles");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    s2_valid_r |-> (idx_r < cell_r.cnt))
    else $error("triangle index past cell count");

  a_idle_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !s2_valid_r |-> (idx_r == '0))
    else $error("triangle index not cleared while idle");

  a_drain_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && last_tri && !cell_valid) |=> !s2_valid_r)
    else $error("cell stays after its last triangle");
`endif

endmodule

// File: design/lod_grid_triangle_index_gen.sv
// Top level: config registers, input register and cell decode for the LOD grid index generator.
//
// Usage:
//   in_*  channel carries one grid cell request: variant and position in in_tdata,
//         region code in in_tuser. Accepted when in_tvalid and in_tready are high.
//   out_* channel carries one triangle per item: three vertex indices in out_tdata,
//         out_tlast marks the final triangle of a request.
//   cfg_* port writes cols_in_use (index 0) or rows_in_use (index 1); values are
//         saturated to 4..MAX_SEGMENTS. Write only while the block is idle.
// Path: a request passes the input register, the held cell and the output register;
//   its triangles leave one per cycle while out_tready is high.
// Throughput: one request per cycle for requests with no triangles; otherwise the next
//   request is taken as the last triangle of the held cell leaves, since the single result
//   register carries one triangle a cycle (inner cells 2, edge cells 1 to 3).
// Reset: clears all valid flags; both sizes return to 64.
// Stall: a low out_tready holds the current triangle; the held cell and the input
//   register then fill and in_tready drops until the output drains.
module lod_grid_triangle_index_gen #(
  parameter int MAX_SEGMENTS = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [lodtri_pkg::IN_TDATA_W-1:0]  in_tdata,   // variant, row, col, zero fill
  input  logic [lodtri_pkg::REGION_W-1:0]    in_tuser,   // region
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [lodtri_pkg::OUT_TDATA_W-1:0] out_tdata,  // vertex_a, vertex_b, vertex_c, zero fill
  output logic                               out_tlast,  // last
  input  logic                               cfg_we,
  input  logic [0:0]                         cfg_index,
  input  logic [lodtri_pkg::SEG_W-1:0]       cfg_wdata
);

  localparam int SEG_W    = lodtri_pkg::SEG_W;
  localparam int STRIDE_W = lodtri_pkg::STRIDE_W;
  localparam int IDX_W    = lodtri_pkg::IDX_W;

  logic [SEG_W-1:0]                 cols_r;
  logic [SEG_W-1:0]                 rows_r;
  logic [SEG_W-1:0]                 cfg_sat;

  logic                             s1_valid_r;
  logic [lodtri_pkg::VAR_W-1:0]     variant_r;
  logic [lodtri_pkg::REGION_W-1:0]  region_r;
  logic [SEG_W-1:0]                 row_r;
  logic [SEG_W-1:0]                 col_r;

  logic [STRIDE_W-1:0]              stride;
  logic [SEG_W-1:0]                 rm1, rm2, cm1, cm2;
  logic [SEG_W-1:0]                 j, i;
  logic                             hit, inner, hi, odd, tail;
  logic [SEG_W+STRIDE_W-1:0]        prod;
  lodtri_pkg::cell_t                dec_cell;
  logic                             cell_valid;
  logic                             cell_ready;

  // config write with saturation
  always_comb begin
    if (cfg_wdata < lodtri_pkg::SEG_MIN) begin
      cfg_sat = lodtri_pkg::SEG_MIN;
    end else if (32'(cfg_wdata) > MAX_SEGMENTS) begin
      cfg_sat = SEG_W'(MAX_SEGMENTS);
    end else begin
      cfg_sat = cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= SEG_W'(64);
      rows_r <= SEG_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_index)
        lodtri_pkg::CFG_COLS: cols_r <= cfg_sat;
        lodtri_pkg::CFG_ROWS: rows_r <= cfg_sat;
        default:              rows_r <= rows_r;
      endcase
    end
  end

  // input register
  assign in_tready = !s1_valid_r || !hit || cell_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      variant_r <= in_tdata[3:0];
      row_r     <= in_tdata[12:4];
      col_r     <= in_tdata[21:13];
      region_r  <= in_tuser;
    end
  end

  // cell decode
  always_comb begin
    stride = STRIDE_W'(cols_r) + STRIDE_W'(1);
    rm1    = rows_r - SEG_W'(1);
    rm2    = rows_r - SEG_W'(2);
    cm1    = cols_r - SEG_W'(1);
    cm2    = cols_r - SEG_W'(2);
    j      = row_r;
    i      = col_r;
    hit    = 1'b0;
    inner  = 1'b0;
    hi     = 1'b0;
    odd    = 1'b0;
    tail   = 1'b0;
    unique case (region_r)
      lodtri_pkg::REGION_INNER: begin
        inner = 1'b1;
        hit   = (row_r >= SEG_W'(1)) && (row_r <= rm2) &&
                (col_r >= SEG_W'(1)) && (col_r <= cm2);
      end
      lodtri_pkg::REGION_TOP: begin
        j    = rm1;
        hit  = (col_r >= SEG_W'(1)) && (col_r <= cm1);
        hi   = variant_r[3];
        odd  = col_r[0];
        tail = (col_r != cm1);
      end
      lodtri_pkg::REGION_RIGHT: begin
        i    = cm1;
        hit  = (row_r >= SEG_W'(1)) && (row_r <= rm1);
        hi   = variant_r[2];
        odd  = row_r[0];
        tail = (row_r != rm1);
      end
      lodtri_pkg::REGION_BOTTOM: begin
        j    = '0;
        hit  = (col_r >= SEG_W'(1)) && (col_r <= cm1);
        hi   = variant_r[1];
        odd  = col_r[0];
        tail = (col_r != cm1);
      end
      lodtri_pkg::REGION_LEFT: begin
        i    = '0;
        hit  = (row_r >= SEG_W'(1)) && (row_r <= rm1);
        hi   = variant_r[0];
        odd  = row_r[0];
        tail = (row_r != rm1);
      end
      default: hit = 1'b0;
    endcase

    prod            = (SEG_W+STRIDE_W)'(j) * (SEG_W+STRIDE_W)'(stride);
    dec_cell.region = lodtri_pkg::region_t'(region_r);
    dec_cell.row_z  = prod[IDX_W-1:0];
    dec_cell.row_p  = prod[IDX_W-1:0] + IDX_W'(stride);
    dec_cell.row_m  = prod[IDX_W-1:0] - IDX_W'(stride);
    dec_cell.col_z  = i;
    dec_cell.col_p  = i + SEG_W'(1);
    dec_cell.col_m  = i - SEG_W'(1);
    dec_cell.shape2 = lodtri_pkg::SH_TAIL;
    priority if (inner) begin
      dec_cell.cnt    = 2'd2;
      dec_cell.shape0 = lodtri_pkg::SH_INNER_A;
      dec_cell.shape1 = lodtri_pkg::SH_INNER_B;
    end else if (!odd) begin
      dec_cell.cnt    = 2'd1;
      dec_cell.shape0 = lodtri_pkg::SH_EVEN;
      dec_cell.shape1 = lodtri_pkg::SH_TAIL;
    end else if (hi) begin
      dec_cell.cnt    = tail ? 2'd3 : 2'd2;
      dec_cell.shape0 = lodtri_pkg::SH_HI_A;
      dec_cell.shape1 = lodtri_pkg::SH_HI_B;
    end else begin
      dec_cell.cnt    = tail ? 2'd2 : 2'd1;
      dec_cell.shape0 = lodtri_pkg::SH_LO;
      dec_cell.shape1 = lodtri_pkg::SH_TAIL;
    end
  end

  assign cell_valid = s1_valid_r && hit;

  lodtri_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .cell_valid (cell_valid),
    .cell_in    (dec_cell),
    .cell_ready (cell_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
